// ===== hw/rtl/spa_pkg.sv =====
package spa_pkg;

	// Field widths of the request and result items
	localparam int COEF_W     = 16;
	localparam int EXP_W      = 16;
	localparam int COEF_SUM_W = 21;

	// Most result terms given per run
	localparam int RES_LIMIT = 32;

	// Saturation bounds of a coefficient sum
	localparam int COEF_SUM_MAX = 1048575;
	localparam int COEF_SUM_MIN = -1048576;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic signed [EXP_W-1:0]  exponent;
		logic                     last_term;
	} term_t;

	typedef struct packed {
		logic signed [COEF_SUM_W-1:0] coefficient_sum;
		logic signed [EXP_W-1:0]      term_exponent;
		logic                         final_result;
		logic                         empty_sum;
		logic                         overflow;
	} result_t;

endpackage

// ===== hw/rtl/spa_ram.sv =====
module spa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/sparse_polynomial_adder_top.sv =====
// Terms load one per cycle while busy is low; the flagged last term starts the merge.
// Merge: repeated scans of the term memory, each reading all N stored terms in order.
// A count pass takes G + 1 scans for G distinct exponents, then an emit pass up to G more.
// Results show for one cycle each, one per emit scan with a nonzero sum, and the receiver
// cannot stall.
// Reset (arst_n low) clears the term count, the overflow flag and the sequencer.
module sparse_polynomial_adder_top #(
	parameter int MAX_TERMS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  spa_pkg::term_t   term,
	output logic             result_valid,
	output spa_pkg::result_t result
);

	import spa_pkg::*;

	localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam int ENT_W  = COEF_W + EXP_W;
	localparam int SUM_W  = (17 + $clog2(MAX_TERMS) > 22) ? 17 + $clog2(MAX_TERMS) : 22;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COEF_SUM_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COEF_SUM_MIN);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PASS_END
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      ovf_q;
	logic                      phase_emit_q;
	logic                      first_q;
	logic signed [EXP_W-1:0]   prev_exp_q;
	logic                      found_q;
	logic signed [EXP_W-1:0]   min_exp_q;
	logic signed [SUM_W-1:0]   acc_q;
	logic [CNT_W-1:0]          rd_idx_q;
	logic                      rd_vld_s1;
	logic                      rd_last_s1;
	logic [CNT_W-1:0]          grp_cnt_q;
	logic [CNT_W-1:0]          emit_cnt_q;
	result_t                   result_q;
	logic                      result_valid_q;

	logic                      accept;
	logic                      wr_en;
	logic                      rd_en;
	logic [ENT_W-1:0]          rd_data;
	logic signed [COEF_W-1:0]  ent_coef;
	logic signed [EXP_W-1:0]   ent_exp;
	logic                      above_prev;
	logic                      take_new;
	logic                      add_on;
	logic signed [SUM_W-1:0]   coef_ext;
	logic signed [COEF_SUM_W-1:0] sat_sum;
	logic                      final_now;
	logic                      run_ovf;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign wr_en        = accept && (int'(cnt_q) < MAX_TERMS);
	assign rd_en        = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Term store: {coefficient, exponent} per entry
	spa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_TERMS)
	) u_term_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data ({term.coefficient, term.exponent}),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// Shared scan unit: find the smallest exponent above the previous one and sum it
	always_comb begin
		ent_coef   = rd_data[ENT_W-1:EXP_W];
		ent_exp    = rd_data[EXP_W-1:0];
		coef_ext   = SUM_W'(ent_coef);
		above_prev = first_q || (ent_exp > prev_exp_q);
		take_new   = above_prev && (!found_q || (ent_exp < min_exp_q));
		add_on     = above_prev && found_q && (ent_exp == min_exp_q);
	end

	// Saturated sum, result numbering and run overflow
	always_comb begin
		int total_i;
		if (acc_q > SAT_HI) begin
			sat_sum = COEF_SUM_W'(COEF_SUM_MAX);
		end else if (acc_q < SAT_LO) begin
			sat_sum = COEF_SUM_W'(COEF_SUM_MIN);
		end else begin
			sat_sum = acc_q[COEF_SUM_W-1:0];
		end
		total_i   = (int'(grp_cnt_q) > RES_LIMIT) ? RES_LIMIT : int'(grp_cnt_q);
		final_now = (int'(emit_cnt_q) + 1 == total_i);
		run_ovf   = ovf_q || (int'(grp_cnt_q) > RES_LIMIT);
	end

	// Sequencer, scan registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
			phase_emit_q   <= 1'b0;
			first_q        <= 1'b1;
			prev_exp_q     <= '0;
			found_q        <= 1'b0;
			min_exp_q      <= '0;
			acc_q          <= '0;
			rd_idx_q       <= '0;
			rd_vld_s1      <= 1'b0;
			rd_last_s1     <= 1'b0;
			grp_cnt_q      <= '0;
			emit_cnt_q     <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (wr_en) begin
							cnt_q <= CNT_W'(cnt_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (term.last_term) begin
							state_q      <= ST_SCAN;
							phase_emit_q <= 1'b0;
							first_q      <= 1'b1;
							found_q      <= 1'b0;
							rd_idx_q     <= '0;
							grp_cnt_q    <= '0;
							emit_cnt_q   <= '0;
						end
					end
				end
				ST_SCAN: begin
					// issue reads in order, process the data in the next cycle
					if (rd_en) begin
						rd_idx_q   <= CNT_W'(rd_idx_q + 1'b1);
						rd_vld_s1  <= 1'b1;
						rd_last_s1 <= (CNT_W'(rd_idx_q + 1'b1) == cnt_q);
					end else begin
						rd_vld_s1  <= 1'b0;
						rd_last_s1 <= 1'b0;
					end
					if (rd_vld_s1) begin
						if (take_new) begin
							found_q   <= 1'b1;
							min_exp_q <= ent_exp;
							acc_q     <= coef_ext;
						end else if (add_on) begin
							acc_q <= acc_q + coef_ext;
						end
						if (rd_last_s1) begin
							state_q <= ST_PASS_END;
						end
					end
				end
				ST_PASS_END: begin
					// next scan starts above this exponent
					state_q    <= ST_SCAN;
					rd_idx_q   <= '0;
					found_q    <= 1'b0;
					first_q    <= 1'b0;
					prev_exp_q <= min_exp_q;
					if (!phase_emit_q) begin
						if (found_q) begin
							if (acc_q != '0) begin
								grp_cnt_q <= CNT_W'(grp_cnt_q + 1'b1);
							end
						end else if (grp_cnt_q == '0) begin
							// everything cancelled: one empty result
							result_q.coefficient_sum <= '0;
							result_q.term_exponent   <= '0;
							result_q.final_result    <= 1'b1;
							result_q.empty_sum       <= 1'b1;
							result_q.overflow        <= ovf_q;
							result_valid_q           <= 1'b1;
							state_q                  <= ST_IDLE;
							cnt_q                    <= '0;
							ovf_q                    <= 1'b0;
						end else begin
							phase_emit_q <= 1'b1;
							first_q      <= 1'b1;
						end
					end else begin
						if (found_q) begin
							if (acc_q != '0) begin
								result_q.coefficient_sum <= sat_sum;
								result_q.term_exponent   <= min_exp_q;
								result_q.final_result    <= final_now;
								result_q.empty_sum       <= 1'b0;
								result_q.overflow        <= run_ovf;
								result_valid_q           <= 1'b1;
								emit_cnt_q               <= CNT_W'(emit_cnt_q + 1'b1);
								if (final_now) begin
									state_q <= ST_IDLE;
									cnt_q   <= '0;
									ovf_q   <= 1'b0;
								end
							end
						end else begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An empty result always closes the run
	a_empty_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.empty_sum |-> result.final_result)
		else $error("empty result without final flag");

	// A non-empty result never carries a zero sum
	a_nonzero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.empty_sum |-> result.coefficient_sum != '0)
		else $error("zero sum emitted");

	// A non-final request produces no result
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !term.last_term |=> !result_valid)
		else $error("result after non-final request");

	// The final result returns the block to idle
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.final_result |-> !busy && cnt_q == '0)
		else $error("block not idle after final result");

	// Scan reads stay within the stored terms
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> rd_idx_q <= cnt_q)
		else $error("scan index past term count");

endmodule
